@@ rtl/http_chunked_body_extractor_top_macros.svh @@
// ----------------------------------------------------------------------------
// HTTP chunked body extractor - assertion macros
// Clocked assertion shorthands shared by the core and result queue RTL files.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_EXTRACTOR_TOP_MACROS_SVH
`define HTTP_CHUNKED_BODY_EXTRACTOR_TOP_MACROS_SVH

// Property that must hold on every clock edge out of reset
`define HCBE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next one
`define HCBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/hcbe_pkg.sv @@
// ----------------------------------------------------------------------------
// HTTP chunked body extractor - package
// Shared types, codes and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbe_pkg;

	// default width of the chunk size counters
	localparam int SIZE_WIDTH_DEF = 32;

	// result queue geometry
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = 2;

	// characters of interest
	localparam logic [7:0] CHR_CR = 8'h0D;
	localparam logic [7:0] CHR_LF = 8'h0A;

	// decoder phase
	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_RAW     = 3'd1,
		PH_SIZE    = 3'd2,
		PH_SIZE_CR = 3'd3,
		PH_DATA    = 3'd4,
		PH_SKIP    = 3'd5,
		PH_DONE    = 3'd6
	} phase_t;

	// end-of-message status
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_HEADER  = 2'd1,
		ST_INCOMPLETE = 2'd2
	} status_t;

	// one result word
	typedef struct packed {
		logic [7:0] body_byte;
		logic       is_status;
		logic [1:0] status_code;
		logic       last_result;
	} result_t;

	// push requests from the decoder to the result queue
	typedef struct packed {
		logic body;
		logic status;
	} push_t;

	// hex digit decode
	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok    = 1'b1;
		h.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.value = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			h.value = c[3:0] + 4'd9;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

`default_nettype wire

@@ rtl/hcbe_core.sv @@
// ----------------------------------------------------------------------------
// HTTP chunked body extractor - decoder core
// Per-byte state machine: header strip, raw pass, chunk size parse, data pass and skip.
// ----------------------------------------------------------------------------
`default_nettype none
`include "http_chunked_body_extractor_top_macros.svh"

module hcbe_core
	import hcbe_pkg::*;
#(
	parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	input  wire logic       end_of_message,
	input  wire logic       chunked_enable,
	output push_t           push,
	output result_t         body_res,
	output result_t         status_res
);

	localparam int SW = SIZE_WIDTH;

	phase_t          phase_q, phase_step, phase_d;
	logic [1:0]      header_match_q, match_d;
	logic [SW-1:0]   size_accum_q, accum_d;
	logic            hex_stopped_q, stopped_d;
	logic [SW-1:0]   bytes_left_q, left_d, left_dec;
	logic [1:0]      skip_left_q, skip_d, skip_dec;
	logic [7:0]      want;
	hex_t            hex;
	logic [SW+3:0]   acc_wide;
	status_t         code;

	// next-state logic
	always_comb begin
		phase_step = phase_q;
		match_d    = header_match_q;
		accum_d    = size_accum_q;
		stopped_d  = hex_stopped_q;
		left_d     = bytes_left_q;
		skip_d     = skip_left_q;
		want       = header_match_q[0] ? CHR_LF : CHR_CR;
		hex        = hex_decode(rx_byte);
		acc_wide   = {size_accum_q, 4'b0000} + {{SW{1'b0}}, hex.value};
		left_dec   = (bytes_left_q != '0) ? bytes_left_q - {{(SW-1){1'b0}}, 1'b1}
			: bytes_left_q;
		skip_dec   = (skip_left_q != 2'd0) ? skip_left_q - 2'd1 : skip_left_q;

		unique case (phase_q)
			PH_HEADER: begin
				if (rx_byte == want) begin
					if (header_match_q == 2'd3) begin
						match_d = 2'd0;
						if (chunked_enable) begin
							phase_step = PH_SIZE;
							accum_d    = '0;
							stopped_d  = 1'b0;
						end else begin
							phase_step = PH_RAW;
						end
					end else begin
						match_d = header_match_q + 2'd1;
					end
				end else begin
					match_d = (rx_byte == CHR_CR) ? 2'd1 : 2'd0;
				end
			end
			PH_RAW: begin
			end
			PH_SIZE, PH_SIZE_CR: begin
				if (phase_q == PH_SIZE_CR && rx_byte == CHR_LF) begin
					if (size_accum_q == '0) begin
						phase_step = PH_DONE;
					end else begin
						left_d     = size_accum_q;
						phase_step = PH_DATA;
					end
				end else begin
					// digits stop at the first non-hex character; size saturates
					if (!hex.ok || hex_stopped_q) begin
						stopped_d = 1'b1;
					end else if (acc_wide[SW+3:SW] != 4'd0) begin
						accum_d = '1;
					end else begin
						accum_d = acc_wide[SW-1:0];
					end
					phase_step = (rx_byte == CHR_CR) ? PH_SIZE_CR : PH_SIZE;
				end
			end
			PH_DATA: begin
				left_d = left_dec;
				if (left_dec == '0) begin
					skip_d     = 2'd2;
					phase_step = PH_SKIP;
				end
			end
			PH_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 2'd0) begin
					phase_step = PH_SIZE;
					accum_d    = '0;
					stopped_d  = 1'b0;
				end
			end
			default: begin
				// finished phase and unused code drop bytes
			end
		endcase

		// end of message clears everything for the next response
		phase_d = phase_step;
		if (end_of_message) begin
			phase_d   = PH_HEADER;
			match_d   = 2'd0;
			accum_d   = '0;
			stopped_d = 1'b0;
			left_d    = '0;
			skip_d    = 2'd0;
		end
	end

	// output logic
	always_comb begin
		unique case (phase_step)
			PH_HEADER:                              code = ST_NO_HEADER;
			PH_SIZE, PH_SIZE_CR, PH_DATA, PH_SKIP:  code = ST_INCOMPLETE;
			default:                                code = ST_OK;
		endcase
		push.body              = step && (phase_q == PH_RAW || phase_q == PH_DATA);
		push.status            = step && end_of_message;
		body_res.body_byte     = rx_byte;
		body_res.is_status     = 1'b0;
		body_res.status_code   = ST_OK;
		body_res.last_result   = 1'b0;
		status_res.body_byte   = 8'h00;
		status_res.is_status   = 1'b1;
		status_res.status_code = code;
		status_res.last_result = 1'b1;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			header_match_q <= 2'd0;
			size_accum_q   <= '0;
			hex_stopped_q  <= 1'b0;
			bytes_left_q   <= '0;
			skip_left_q    <= 2'd0;
		end else if (step) begin
			phase_q        <= phase_d;
			header_match_q <= match_d;
			size_accum_q   <= accum_d;
			hex_stopped_q  <= stopped_d;
			bytes_left_q   <= left_d;
			skip_left_q    <= skip_d;
		end
	end

	`HCBE_ASSERT_NEXT(a_eom_clears, clk, arst_n, step && end_of_message, phase_q == PH_HEADER && size_accum_q == '0 && bytes_left_q == '0, "state not cleared after end of message")
	`HCBE_ASSERT_NEXT(a_data_to_skip, clk, arst_n, step && !end_of_message && phase_q == PH_DATA && bytes_left_q == {{(SW-1){1'b0}}, 1'b1}, phase_q == PH_SKIP && skip_left_q == 2'd2, "last data byte did not enter skip")
	`HCBE_ASSERT(a_data_count, clk, arst_n, phase_q != PH_DATA || bytes_left_q != '0, "data phase with zero bytes left")

endmodule

`default_nettype wire

@@ rtl/hcbe_rq.sv @@
// ----------------------------------------------------------------------------
// HTTP chunked body extractor - result queue
// Four-word queue taking up to two words per cycle, draining one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "http_chunked_body_extractor_top_macros.svh"

module hcbe_rq
	import hcbe_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire push_t   push,
	input  wire result_t body_res,
	input  wire result_t status_res,
	output logic         room,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      head
);

	localparam logic [RQ_AW:0] DEPTH_C = (RQ_AW+1)'(RQ_DEPTH);
	localparam logic [RQ_AW:0] ROOM_C  = (RQ_AW+1)'(RQ_DEPTH - 2);

	result_t          mem [RQ_DEPTH];
	logic [RQ_AW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr2;
	logic [RQ_AW:0]   count_q, count_d;
	logic             pop;

	// flow control
	assign room      = count_q <= ROOM_C;
	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign head      = mem[rd_ptr_q];
	assign wr_ptr2   = wr_ptr_q + {{(RQ_AW-1){1'b0}}, push.body};

	always_comb begin
		count_d = count_q + {{RQ_AW{1'b0}}, push.body} + {{RQ_AW{1'b0}}, push.status}
			- {{RQ_AW{1'b0}}, pop};
	end

	// storage: body word first, status word after it
	always_ff @(posedge clk) begin
		if (push.body) begin
			mem[wr_ptr_q] <= body_res;
		end
		if (push.status) begin
			mem[wr_ptr2] <= status_res;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + {{(RQ_AW-1){1'b0}}, push.body}
				+ {{(RQ_AW-1){1'b0}}, push.status};
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + {{(RQ_AW-1){1'b0}}, 1'b1};
			end
			count_q <= count_d;
		end
	end

	`HCBE_ASSERT(a_push_room, clk, arst_n, !(push.body || push.status) || count_q <= ROOM_C, "push into queue without room")
	`HCBE_ASSERT(a_count_range, clk, arst_n, count_q <= DEPTH_C, "queue count beyond depth")

endmodule

`default_nettype wire

@@ rtl/http_chunked_body_extractor_top.sv @@
// ----------------------------------------------------------------------------
// HTTP chunked body extractor - top level
// Strips the HTTP header and delivers body bytes, decoding chunked bodies.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one response byte per word with
//   end_of_message flagging the final byte. Output channel (out_valid/out_ready)
//   carries result words: body bytes, and on end_of_message a status word
//   (is_status = 1, last_result = 1) after any body byte of that input word.
//   cfg_valid/cfg_ready/cfg_data writes chunked_enable; write it while idle.
// Timing:
//   Input register, then the decoder writes results into a four-word queue:
//   a body byte is held in the input register and written into the queue
//   before it is offered on the output. One input word per cycle is
//   sustained while the queue has room; a word that yields both a body byte
//   and a status word puts both words into the queue.
// Reset:
//   arst_n clears the decoder to the header phase, empties the queue and
//   clears chunked_enable.
// Stall:
//   When out_ready is low the queue fills; in_ready drops while the input
//   register holds a word and fewer than two free queue entries remain.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_extractor_top
	import hcbe_pkg::*;
#(
	parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_data,
	// input bytes
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       end_of_message,
	// results
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      body_byte,
	output logic            is_status,
	output logic [1:0]      status_code,
	output logic            last_result
);

	logic       chunked_enable_q;
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       eom_s1;
	logic       room;
	logic       step;
	push_t      push;
	result_t    body_res, status_res, head;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunked_enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			chunked_enable_q <= cfg_data;
		end
	end

	// input register
	assign step     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
			eom_s1     <= end_of_message;
		end
	end

	// decoder
	hcbe_core #(
		.SIZE_WIDTH (SIZE_WIDTH)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.rx_byte        (rx_byte_s1),
		.end_of_message (eom_s1),
		.chunked_enable (chunked_enable_q),
		.push           (push),
		.body_res       (body_res),
		.status_res     (status_res)
	);

	// result queue
	hcbe_rq u_rq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.body_res   (body_res),
		.status_res (status_res),
		.room       (room),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.head       (head)
	);

	assign body_byte   = head.body_byte;
	assign is_status   = head.is_status;
	assign status_code = head.status_code;
	assign last_result = head.last_result;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP chunked body extractor - testbench
// Builds HTTP responses (plain and chunked, well-formed, cut short and junk)
// and sends them byte by byte with random gaps and output back-pressure.
// A scoreboard class decodes the same byte stream and checks every result
// word field by field, in order.
// ----------------------------------------------------------------------------

module tb_top
	import hcbe_pkg::*;
();

	localparam int SIZE_W       = SIZE_WIDTH_DEF;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_BYTES = 1200;

	// decodes the byte stream and keeps the result words still to come
	class body_scoreboard;
		result_t     due_words[$];
		int unsigned errors;
		logic        chunked;
		phase_t      phase;
		logic [1:0]  crlf_seen;
		logic [63:0] size_acc;
		logic        hex_stop;
		logic [63:0] data_left;
		logic [1:0]  skip_left;

		function new();
			errors  = 0;
			chunked = 1'b0;
			clear_message();
		endfunction

		function void clear_message();
			phase     = PH_HEADER;
			crlf_seen = 2'd0;
			size_acc  = 64'd0;
			hex_stop  = 1'b0;
			data_left = 64'd0;
			skip_left = 2'd0;
		endfunction

		function void open_size_line();
			phase    = PH_SIZE;
			size_acc = 64'd0;
			hex_stop = 1'b0;
		endfunction

		// value of a hex digit, -1 for anything else
		function int nibble(input logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
			if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
			if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
			return -1;
		endfunction

		function void due(input logic [7:0] b, input logic st, input logic [1:0] code,
				input logic last);
			result_t r;
			r.body_byte   = b;
			r.is_status   = st;
			r.status_code = code;
			r.last_result = last;
			due_words.push_back(r);
		endfunction

		// one accepted input word
		function void take_byte(input logic [7:0] c, input logic eom);
			int          d;
			logic [63:0] dv;
			logic [63:0] sat;
			status_t     code;
			sat = (64'd1 << SIZE_W) - 64'd1;
			case (phase)
				PH_HEADER: begin
					if (c == (crlf_seen[0] ? CHR_LF : CHR_CR)) begin
						if (crlf_seen == 2'd3) begin
							crlf_seen = 2'd0;
							if (chunked)
								open_size_line();
							else
								phase = PH_RAW;
						end else begin
							crlf_seen = crlf_seen + 2'd1;
						end
					end else begin
						crlf_seen = (c == CHR_CR) ? 2'd1 : 2'd0;
					end
				end
				PH_RAW: due(c, 1'b0, ST_OK, 1'b0);
				PH_SIZE, PH_SIZE_CR: begin
					if (phase == PH_SIZE_CR && c == CHR_LF) begin
						if (size_acc == 64'd0) begin
							phase = PH_DONE;
						end else begin
							data_left = size_acc;
							phase     = PH_DATA;
						end
					end else begin
						d = nibble(c);
						if (d < 0 || hex_stop) begin
							hex_stop = 1'b1;
						end else begin
							dv = 64'(d);
							// saturate rather than wrap
							if (size_acc > ((sat - dv) >> 4))
								size_acc = sat;
							else
								size_acc = (size_acc << 4) + dv;
						end
						phase = (c == CHR_CR) ? PH_SIZE_CR : PH_SIZE;
					end
				end
				PH_DATA: begin
					due(c, 1'b0, ST_OK, 1'b0);
					if (data_left != 64'd0) data_left = data_left - 64'd1;
					if (data_left == 64'd0) begin
						skip_left = 2'd2;
						phase     = PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (skip_left != 2'd0) skip_left = skip_left - 2'd1;
					if (skip_left == 2'd0) open_size_line();
				end
				default: ;
			endcase

			// status word closes the message
			if (eom) begin
				if (phase == PH_HEADER)
					code = ST_NO_HEADER;
				else if (phase inside {PH_SIZE, PH_SIZE_CR, PH_DATA, PH_SKIP})
					code = ST_INCOMPLETE;
				else
					code = ST_OK;
				due(8'h00, 1'b1, code, 1'b1);
				clear_message();
			end
		endfunction

		task report(input string what);
			$display("[%0t] mismatch: %s", $time, what);
			errors++;
		endtask

		// one accepted result word against the oldest one due
		task match_word(input result_t got);
			result_t want;
			if (due_words.size() == 0) begin
				report("result word with nothing due");
				return;
			end
			want = due_words.pop_front();
			if (got.body_byte !== want.body_byte)
				report($sformatf("body_byte %h, want %h", got.body_byte, want.body_byte));
			if (got.is_status !== want.is_status)
				report($sformatf("is_status %b, want %b", got.is_status, want.is_status));
			if (got.status_code !== want.status_code)
				report($sformatf("status_code %0d, want %0d", got.status_code,
					want.status_code));
			if (got.last_result !== want.last_result)
				report($sformatf("last_result %b, want %b", got.last_result,
					want.last_result));
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] rx_byte;
	logic       end_of_message;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] body_byte;
	logic       is_status;
	logic [1:0] status_code;
	logic       last_result;

	body_scoreboard sb = new();
	logic [7:0]     msg_q[$];
	bit             burst;
	bit             hold_request;

	http_chunked_body_extractor_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.body_byte      (body_byte),
		.is_status      (is_status),
		.status_code    (status_code),
		.last_result    (last_result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// message building
	function automatic void add_byte(input logic [7:0] b);
		msg_q.push_back(b);
	endfunction

	function automatic void add_crlf();
		msg_q.push_back(CHR_CR);
		msg_q.push_back(CHR_LF);
	endfunction

	function automatic void add_str(input string s);
		for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
	endfunction

	function automatic void add_rand(input int n);
		repeat (n) msg_q.push_back(8'($urandom_range(0, 255)));
	endfunction

	// hex size line: mixed case, leading zeros, text after the digits
	function automatic void add_size_line(input logic [63:0] size);
		string s;
		int    pad;
		s = $sformatf("%0h", size);
		if ($urandom_range(0, 1) == 1) s = s.toupper();
		pad = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
		repeat (pad) s = {"0", s};
		case ($urandom_range(0, 9))
			0: s = {s, ";ext=9f"};
			1: s = {s, " 7"};
			default: ;
		endcase
		add_str(s);
		// lone CR inside the line, not followed by LF
		if ($urandom_range(0, 19) == 0) begin
			add_byte(CHR_CR);
			add_str("q");
		end
		add_crlf();
	endfunction

	function automatic void add_chunk(input int n);
		add_size_line(64'(n));
		add_rand(n);
		if ($urandom_range(0, 4) != 0)
			add_crlf();
		else
			add_rand(2);
	endfunction

	function automatic void build_message(input logic chunked);
		int kind;
		int cut;
		msg_q.delete();
		kind = $urandom_range(0, 99);
		// pure junk, mostly no header end
		if (kind < 6) begin
			add_rand($urandom_range(1, 24));
			return;
		end
		add_rand($urandom_range(0, 10));
		if ($urandom_range(0, 4) == 0) begin
			add_crlf();
			add_byte(CHR_CR);
			add_rand(1);
		end
		if ($urandom_range(0, 3) == 0) add_byte(CHR_CR);
		add_crlf();
		add_crlf();
		if (!chunked || kind < 14) begin
			add_rand($urandom_range(0, 30));
		end else begin
			repeat ($urandom_range(0, 4))
				add_chunk(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) :
					$urandom_range(1, 8));
			if (kind < 24) begin
				// size past the counter width, message ends inside the data
				add_size_line({$urandom, $urandom} | 64'h1_0000_0000);
				add_rand($urandom_range(0, 6));
			end else if (kind < 31) begin
				add_str("zz");
				add_crlf();
				add_rand($urandom_range(0, 4));
			end else begin
				add_size_line(64'd0);
				add_rand($urandom_range(0, 6));
				add_crlf();
			end
		end
		// occasionally cut the message short
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, msg_q.size());
			while (msg_q.size() > cut) void'(msg_q.pop_back());
		end
	endfunction

	// sender side
	function automatic int idle_cycles();
		int r;
		if (burst) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic eom);
		int gap;
		in_valid       <= 1'b1;
		rx_byte        <= b;
		end_of_message <= eom;
		do @(posedge clk); while (!in_ready);
		sb.take_byte(b, eom);
		gap = idle_cycles();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_message();
		for (int i = 0; i < msg_q.size(); i++)
			push_byte(msg_q[i], i == msg_q.size() - 1);
	endtask

	// stop sending and wait for every due word
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.due_words.size() != 0) @(posedge clk);
	endtask

	task automatic settle();
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_chunked(input logic v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.chunked = v;
	endtask

	// receiver: ready in runs of random length, one long hold on request
	initial begin : rx_side
		int      run_left;
		int      hold_left;
		logic    level;
		result_t got;
		out_ready = 1'b0;
		run_left  = 0;
		hold_left = 0;
		level     = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.body_byte   = body_byte;
				got.is_status   = is_status;
				got.status_code = status_code;
				got.last_result = last_result;
				sb.match_word(got);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					level    = ~level;
					run_left = level ? $urandom_range(1, 30) :
						(($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) :
						$urandom_range(1, 3));
				end
				run_left--;
				out_ready <= level;
			end
		end
	end

	// stimulus
	initial begin : stimulus
		int n_random;
		bit hold_done;
		bit pause_done;
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = 1'b0;
		in_valid       = 1'b0;
		rx_byte        = 8'h00;
		end_of_message = 1'b0;
		hold_request   = 1'b0;
		burst          = 1'b0;
		hold_done      = 1'b0;
		pause_done     = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_chunked(1'b0);
		// header cut short
		msg_q.delete();
		add_str("x");
		send_message();
		// plain body; CR restarts the terminator match; extreme byte values
		msg_q.delete();
		add_byte(CHR_CR);
		add_crlf();
		add_crlf();
		add_byte(8'h00);
		add_byte(8'hFF);
		send_message();
		settle();
		write_chunked(1'b1);
		// header ends on the final byte
		msg_q.delete();
		add_crlf();
		add_crlf();
		send_message();
		// one chunk, odd bytes after the data, size line with no hex digit
		msg_q.delete();
		add_crlf();
		add_crlf();
		add_str("1");
		add_crlf();
		add_str("Axxg");
		add_crlf();
		send_message();

		n_random = 0;
		while (n_random < RANDOM_BYTES) begin
			if ($urandom_range(0, 3) == 0) begin
				settle();
				write_chunked(1'($urandom_range(0, 1)));
			end
			burst = ($urandom_range(0, 3) == 0);
			build_message(sb.chunked);
			if (!hold_done && n_random >= 300) begin
				hold_request = 1'b1;
				hold_done    = 1'b1;
			end
			if (!pause_done && n_random >= 700) begin
				drain();
				pause_done = 1'b1;
			end
			send_message();
			n_random += msg_q.size();
		end

		drain();
		repeat (DRAIN_CYCLES * 4) @(posedge clk);
		if (sb.errors == 0 && sb.due_words.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/hcbe_pkg.sv
rtl/hcbe_core.sv
rtl/hcbe_rq.sv
rtl/http_chunked_body_extractor_top.sv
bench/tb_top.sv
